>>> hdl/mhpq_pkg.sv
// Types shared by the max-heap priority queue: item structs and codes.
// No dependencies.
`default_nettype none

package mhpq_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  top_value;
      logic                      top_valid;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/max_heap_priority_queue.sv
// Binary max-heap priority queue: heap array in a memory, walked by a small sequencer.
// Insert climbs from the new last slot toward the root; remove moves the last entry to the root
// and sifts it down, each over up to ceil(log2(CAPACITY+1)) - 1 levels; full and empty go
// straight to the response state. One item at a time: req_ready is high only while idle,
// and the next item can be taken in the same cycle as the result first shows rsp_valid.
// Reset empties the heap; contents undefined. Depends on mhpq_pkg.
`default_nettype none

module max_heap_priority_queue #(
   parameter int unsigned CAPACITY = 127
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  mhpq_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output mhpq_pkg::rsp_type   rsp_payload
);

   localparam int unsigned IDX_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_CHECK,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   state_type                           state_ff, state_in;
   logic [IDX_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic signed [mhpq_pkg::DATA_W-1:0]  val_ff, val_in;
   logic signed [mhpq_pkg::DATA_W-1:0]  root_ff, root_in;
   logic                                right_ok_ff, right_ok_in;
   mhpq_pkg::status_type                status_ff, status_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::rsp_type                   rsp_ff, rsp_in;

   // heap memory, slot 0 unused
   logic signed [mhpq_pkg::DATA_W-1:0]  heap_mem [CAPACITY+1];
   logic signed [mhpq_pkg::DATA_W-1:0]  rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]                    rd_addr_a, rd_addr_b;
   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   logic signed [mhpq_pkg::DATA_W-1:0]  wr_data;

   logic [IDX_W:0]                      left_idx, right_idx, count_ext;
   logic                                take_right;
   logic signed [mhpq_pkg::DATA_W-1:0]  child_val;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign left_idx   = {idx_ff, 1'b0};
   assign right_idx  = {idx_ff, 1'b1};
   assign count_ext  = {1'b0, count_ff};
   assign take_right = right_ok_ff && (rd_a_ff < rd_b_ff);
   assign child_val  = take_right ? rd_b_ff : rd_a_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      right_ok_in  = right_ok_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = val_ff;
      rd_addr_a    = idx_ff >> 1;
      rd_addr_b    = idx_ff >> 1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = mhpq_pkg::STATUS_OK;
               if (req_payload.op == mhpq_pkg::OP_INSERT) begin
                  if (count_ff >= IDX_W'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     count_in = count_ff + 1'b1;
                     idx_in   = count_ff + 1'b1;
                     val_in   = req_payload.value;
                     state_in = ST_UP_CHECK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     rd_addr_a = count_ff;       // last entry moves to the root
                     count_in  = count_ff - 1'b1;
                     idx_in    = IDX_W'(1);
                     state_in  = ST_DN_LAST;
                  end
               end
            end
         end
         ST_UP_CHECK: begin
            if (idx_ff == IDX_W'(1)) begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_addr_a = idx_ff >> 1;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_a_ff < val_ff) begin
               // parent moves down into the hole
               wr_data  = rd_a_ff;
               idx_in   = idx_ff >> 1;
               state_in = ST_UP_CHECK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DN_LAST: begin
            val_in   = rd_a_ff;
            state_in = (count_ff == '0) ? ST_RESP : ST_DN_CHECK;
         end
         ST_DN_CHECK: begin
            if (left_idx > count_ext) begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end else begin
               right_ok_in = (right_idx <= count_ext);
               rd_addr_a   = left_idx[IDX_W-1:0];
               rd_addr_b   = (right_idx <= count_ext) ? right_idx[IDX_W-1:0]
                                                      : left_idx[IDX_W-1:0];
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (val_ff < child_val) begin
               // larger child moves up into the hole; ties keep the left child
               wr_data  = child_val;
               idx_in   = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
               state_in = ST_DN_CHECK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.top_valid = (count_ff != '0);
               rsp_in.top_value = (count_ff != '0) ? root_ff : '0;
               rsp_in.count     = mhpq_pkg::COUNT_W'(count_ff);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shadow copy of slot 1 for the reported maximum
      root_in = (wr_en && wr_addr == IDX_W'(1)) ? wr_data : root_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      root_ff     <= root_in;
      right_ok_ff <= right_ok_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire

>>> tb/sv/max_heap_priority_queue_tb.sv
// Self-checking testbench for the max-heap priority queue: inserts and removes, empty and
// full cases, equal keys and random traffic with idle gaps on both channels.
// Depends on mhpq_pkg and max_heap_priority_queue.
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

   localparam int unsigned HEAP_CAP     = 127;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 64;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mhpq_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   mhpq_pkg::rsp_type rsp_payload;

   // Predicted heap contents, 1-based like the hardware
   logic signed [31:0] heap_mem [1:HEAP_CAP];
   int unsigned        heap_size;
   mhpq_pkg::rsp_type  predicted_reports [$];

   bit          no_idle;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned reports_checked;
   int unsigned full_hits;
   int unsigned empty_hits;
   int unsigned peak_size;
   int unsigned cycle_count;

   max_heap_priority_queue #(
      .CAPACITY (HEAP_CAP)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still due",
                  $time, cycle_count, predicted_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(19, 0);
   endfunction

   // Mix of full-range, clustered (lots of equal keys) and extreme values
   function automatic logic signed [31:0] draw_value();
      case ($urandom_range(3, 0))
         0: return $signed($urandom_range(8, 0)) - 4;
         1: begin
            case ($urandom_range(3, 0))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Applies one operation to the predicted heap and returns the report it should give
   function automatic mhpq_pkg::rsp_type heap_apply(input mhpq_pkg::req_type item);
      int unsigned        idx;
      int unsigned        parent;
      int unsigned        left;
      int unsigned        big;
      logic signed [31:0] tmp;
      mhpq_pkg::rsp_type  report;

      report.status = mhpq_pkg::STATUS_OK;
      if (item.op == mhpq_pkg::OP_INSERT) begin
         if (heap_size >= HEAP_CAP) begin
            report.status = mhpq_pkg::STATUS_FULL;
         end else begin
            heap_size++;
            heap_mem[heap_size] = item.value;
            idx = heap_size;
            while (idx > 1) begin
               parent = idx / 2;
               if (heap_mem[parent] >= heap_mem[idx]) break;
               tmp              = heap_mem[parent];
               heap_mem[parent] = heap_mem[idx];
               heap_mem[idx]    = tmp;
               idx              = parent;
            end
         end
      end else begin
         if (heap_size == 0) begin
            report.status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            heap_mem[1] = heap_mem[heap_size];
            heap_size--;
            idx = 1;
            forever begin
               left = 2 * idx;
               big  = idx;
               // strict compares: ties keep the parent, then prefer the left child
               if (left <= heap_size && heap_mem[big] < heap_mem[left]) big = left;
               if (left + 1 <= heap_size && heap_mem[big] < heap_mem[left + 1]) big = left + 1;
               if (big == idx) break;
               tmp           = heap_mem[big];
               heap_mem[big] = heap_mem[idx];
               heap_mem[idx] = tmp;
               idx           = big;
            end
         end
      end

      report.top_valid = (heap_size > 0);
      report.top_value = (heap_size > 0) ? heap_mem[1] : 32'sd0;
      report.count     = heap_size[mhpq_pkg::COUNT_W-1:0];
      return report;
   endfunction

   // Leaves req_valid high after acceptance so a zero-gap item follows without a bubble
   task automatic send_item(input mhpq_pkg::op_type op, input logic signed [31:0] value);
      int unsigned       gap;
      mhpq_pkg::req_type item;
      mhpq_pkg::rsp_type report;

      gap        = draw_wait();
      item.op    = op;
      item.value = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_ready !== 1'b1);

      report = heap_apply(item);
      predicted_reports.push_back(report);
      items_sent++;
      if (report.status == mhpq_pkg::STATUS_FULL) full_hits++;
      if (report.status == mhpq_pkg::STATUS_EMPTY) empty_hits++;
      if (heap_size > peak_size) peak_size = heap_size;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch on result %0d, expected %0h, got %0h",
               $time, field, reports_checked, want, got);
   endtask

   // Result side: random stalls on rsp_ready, each item compared with the oldest prediction
   initial begin : result_checker
      int unsigned       stall;
      mhpq_pkg::rsp_type want;
      mhpq_pkg::rsp_type got;

      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = rsp_payload;
         if (predicted_reports.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got %0h", $time, got);
         end else begin
            want = predicted_reports.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", want.status, got.status);
            if (got.top_value !== want.top_value)
               report_mismatch("top_value", want.top_value, got.top_value);
            if (got.top_valid !== want.top_valid)
               report_mismatch("top_valid", want.top_valid, got.top_valid);
            if (got.count !== want.count)
               report_mismatch("count", want.count, got.count);
            reports_checked++;
         end
      end
   end

   task automatic test_remove_on_empty();
      send_item(mhpq_pkg::OP_REMOVE, 32'sd0);
      send_item(mhpq_pkg::OP_REMOVE, VALUE_MIN);
   endtask

   task automatic test_extreme_values();
      send_item(mhpq_pkg::OP_INSERT, VALUE_MIN);
      send_item(mhpq_pkg::OP_INSERT, -32'sd1);
      send_item(mhpq_pkg::OP_INSERT, VALUE_MAX);
      send_item(mhpq_pkg::OP_INSERT, 32'sd0);
      send_item(mhpq_pkg::OP_INSERT, 32'sd1);
      repeat (5) send_item(mhpq_pkg::OP_REMOVE, VALUE_MAX);
   endtask

   task automatic test_equal_keys();
      send_item(mhpq_pkg::OP_INSERT, 32'sd7);
      send_item(mhpq_pkg::OP_INSERT, 32'sd7);
      send_item(mhpq_pkg::OP_INSERT, -32'sd3);
      send_item(mhpq_pkg::OP_INSERT, 32'sd7);
      repeat (4) send_item(mhpq_pkg::OP_REMOVE, -32'sd1);
   endtask

   // Fill to capacity, hit the full case, then drain past empty
   task automatic test_fill_and_drain();
      no_idle = ($urandom_range(1, 0) == 0);
      while (heap_size < HEAP_CAP) send_item(mhpq_pkg::OP_INSERT, draw_value());
      send_item(mhpq_pkg::OP_INSERT, VALUE_MAX);
      send_item(mhpq_pkg::OP_INSERT, draw_value());
      while (heap_size > 0) send_item(mhpq_pkg::OP_REMOVE, draw_value());
      send_item(mhpq_pkg::OP_REMOVE, draw_value());
      no_idle = 1'b0;
   endtask

   // Segments with different insert bias so the fill level wanders over the whole range
   task automatic test_random_mix(input int unsigned total);
      int unsigned      done;
      int unsigned      seg_len;
      int unsigned      insert_pct;
      int unsigned      k;
      mhpq_pkg::op_type op;

      done = 0;
      while (done < total) begin
         seg_len = $urandom_range(80, 20);
         case ($urandom_range(3, 0))
            0: insert_pct = 90;
            1: insert_pct = 50;
            2: insert_pct = 15;
            default: insert_pct = 65;
         endcase
         no_idle = ($urandom_range(3, 0) == 0);
         for (k = 0; k < seg_len && done < total; k++) begin
            op = ($urandom_range(99, 0) < insert_pct) ? mhpq_pkg::OP_INSERT
                                                      : mhpq_pkg::OP_REMOVE;
            send_item(op, draw_value());
            done++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      no_idle         = 1'b0;
      heap_size       = 0;
      error_count     = 0;
      items_sent      = 0;
      reports_checked = 0;
      full_hits       = 0;
      empty_hits      = 0;
      peak_size       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_remove_on_empty();
      test_extreme_values();
      test_equal_keys();
      test_fill_and_drain();
      test_random_mix(1620);

      req_valid <= 1'b0;
      while (predicted_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items, checked %0d results; peak fill %0d of %0d entries.",
               items_sent, reports_checked, peak_size, HEAP_CAP);
      $display("Rejected inserts on a full heap: %0d, removes on an empty heap: %0d.",
               full_hits, empty_hits);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/mhpq_pkg.sv
hdl/max_heap_priority_queue.sv
tb/sv/max_heap_priority_queue_tb.sv
